>>> rtl/lzwc_pkg.sv
// ----------------------------------------------------------------------------
// LZW compressor package
// Shared types and constants for the LZW compressor cell chain.
// ----------------------------------------------------------------------------
package lzwc_pkg;

	localparam int CELL_BITS = 5;
	localparam int NUM_CELLS = 1 << CELL_BITS;
	localparam int SYM_W     = 8;
	localparam int CODE_OUT_W = 12;
	localparam int POS_W     = 13;

	// first free code right after reset (symbol_bits = 8)
	localparam logic [POS_W-1:0] RESET_FIRST = 13'd258;

	typedef enum logic [1:0] {
		CMD_SYMBOL = 2'd0,
		CMD_FLUSH  = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic {
		REG_SYMBOL_BITS   = 1'b0,
		REG_MAX_CODE_BITS = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// search token moving along the cell chain
	typedef struct packed {
		logic valid;
		logic last;
		logic hit;
	} tok_t;

	// decoded configuration, saturated to the legal ranges
	typedef struct packed {
		logic [SYM_W-1:0] sym_mask;
		logic [POS_W-1:0] first;
		logic [POS_W-1:0] cap_pow;
	} cfg_t;

endpackage

>>> rtl/lzwc_cfg.sv
// ----------------------------------------------------------------------------
// LZW compressor configuration registers
// APB register file for symbol_bits and max_code_bits, with range decode.
// ----------------------------------------------------------------------------
module lzwc_cfg
	import lzwc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [3:0] symbol_bits_q;
	logic [3:0] max_code_bits_q;
	logic [3:0] sb_eff;
	logic [3:0] mcb_eff;
	reg_idx_t   idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_bits_q   <= 4'd8;
			max_code_bits_q <= 4'd12;
		end else if (wr) begin
			case (idx)
				REG_SYMBOL_BITS:   symbol_bits_q   <= pwdata[3:0];
				REG_MAX_CODE_BITS: max_code_bits_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SYMBOL_BITS:   prdata = {28'd0, symbol_bits_q};
			REG_MAX_CODE_BITS: prdata = {28'd0, max_code_bits_q};
			default:           prdata = 32'd0;
		endcase
	end

	// saturate to 1..8 and 9..12
	assign sb_eff  = (symbol_bits_q < 4'd1) ? 4'd1 :
		(symbol_bits_q > 4'd8) ? 4'd8 : symbol_bits_q;
	assign mcb_eff = (max_code_bits_q < 4'd9) ? 4'd9 :
		(max_code_bits_q > 4'd12) ? 4'd12 : max_code_bits_q;

	assign cfg.sym_mask = SYM_W'((9'd1 << sb_eff) - 9'd1);
	assign cfg.first    = (13'd1 << sb_eff) + 13'd2;
	assign cfg.cap_pow  = 13'd1 << mcb_eff;

endmodule

>>> rtl/lzwc_cell.sv
// ----------------------------------------------------------------------------
// LZW compressor dictionary cell
// Holds every NUM_CELLS-th dictionary entry and matches one row per cycle.
// ----------------------------------------------------------------------------
module lzwc_cell
	import lzwc_pkg::*;
#(
	parameter int ADDR_W   = 7,
	parameter int CELL_IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tok_t                        in_tok,
	input  logic [ADDR_W-1:0]           in_addr,
	input  logic [ADDR_W+CELL_BITS-1:0] in_code,
	input  logic [ADDR_W+CELL_BITS-1:0] key_prefix,
	input  logic [SYM_W-1:0]            key_sym,
	input  logic [POS_W-1:0]            lo_code,
	input  logic [POS_W-1:0]            hi_code,
	input  logic                        wr_en,
	input  logic [ADDR_W-1:0]           wr_addr,
	input  logic [ADDR_W+CELL_BITS-1:0] wr_prefix,
	input  logic [SYM_W-1:0]            wr_sym,
	output tok_t                        out_tok,
	output logic [ADDR_W-1:0]           out_addr,
	output logic [ADDR_W+CELL_BITS-1:0] out_code
);

	localparam int CODE_W = ADDR_W + CELL_BITS;
	localparam int DEPTH  = 1 << ADDR_W;

	logic [CODE_W-1:0] mem_prefix [DEPTH];
	logic [SYM_W-1:0]  mem_sym    [DEPTH];

	logic [CODE_W-1:0] rd_prefix_q;
	logic [SYM_W-1:0]  rd_sym_q;
	tok_t              tok_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CODE_W-1:0] code_q;
	logic [CODE_W-1:0] my_code;
	logic [POS_W-1:0]  my_pos;
	logic              match;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_prefix[wr_addr] <= wr_prefix;
			mem_sym[wr_addr]    <= wr_sym;
		end
	end

	always_ff @(posedge clk) begin
		rd_prefix_q <= mem_prefix[in_addr];
		rd_sym_q    <= mem_sym[in_addr];
		addr_q      <= in_addr;
		code_q      <= in_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= in_tok;
		end
	end

	assign my_code = {addr_q, CELL_BITS'(CELL_IDX)};
	assign my_pos  = POS_W'(my_code);

	// only entries between the first free code and next_free are live
	assign match = tok_q.valid && (my_pos >= lo_code) && (my_pos < hi_code) &&
		(rd_prefix_q == key_prefix) && (rd_sym_q == key_sym);

	always_comb begin
		out_tok     = tok_q;
		out_tok.hit = tok_q.hit || match;
		out_addr    = addr_q;
		out_code    = (match && !tok_q.hit) ? my_code : code_q;
	end

endmodule

>>> rtl/lzw_compressor.sv
// ----------------------------------------------------------------------------
// LZW compressor
// Symbol stream in, code stream out; dictionary spread over a cell chain.
// ----------------------------------------------------------------------------
// Sequence: a flush, or a miss on an empty dictionary, goes to EMIT, where the
// output register loads once the output is not stalled. A searched symbol holds
// the input through SCAN (R = 32-code rows from the first free code to next_free,
// one row a cycle) and DRAIN (the 32-cell chain); a miss then goes to EMIT too.
// Throughput: one item at a time; item_stall is high outside IDLE.
// Reset: prefix dropped, next_free = 258, registers at 8 and 12; dictionary
// contents are not cleared.
module lzw_compressor
	import lzwc_pkg::*;
#(
	parameter int DICT_ENTRIES = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [1:0]            command,
	input  logic [SYM_W-1:0]      symbol,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [CODE_OUT_W-1:0] code,
	output logic [POS_W-1:0]      dict_position,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int CODE_W = $clog2(DICT_ENTRIES);
	localparam int ADDR_W = CODE_W - CELL_BITS;
	localparam logic [POS_W-1:0] DICT_POS = POS_W'(DICT_ENTRIES);

	cfg_t cfg;

	state_t state_q, state_d;

	logic                  prefix_valid_q;
	logic [CODE_W-1:0]     prefix_code_q;
	logic [POS_W-1:0]      next_free_q;
	logic [SYM_W-1:0]      sym_q;
	logic [ADDR_W-1:0]     cnt_q;
	logic [ADDR_W-1:0]     last_addr_q;
	logic                  hit_q;
	logic [CODE_W-1:0]     hit_code_q;
	logic [CODE_OUT_W-1:0] res_code_q;
	logic [POS_W-1:0]      res_pos_q;
	logic                  out_valid_q;
	logic [CODE_OUT_W-1:0] code_q;
	logic [POS_W-1:0]      dict_pos_q;

	logic                  take_item;
	logic                  scan_issue;
	logic                  do_hit;
	logic                  do_miss;
	logic                  do_flush;
	logic                  do_clear;
	logic                  do_first;
	logic                  start_scan;
	logic                  load_out;
	logic [SYM_W-1:0]      in_sym;
	logic [SYM_W-1:0]      miss_sym;
	logic [POS_W-1:0]      cap;
	logic                  room;
	logic [POS_W-1:0]      nf_m1;
	logic [CODE_W-1:0]     final_code;
	logic [NUM_CELLS-1:0]  cell_wr;

	tok_t              tok   [NUM_CELLS+1];
	logic [ADDR_W-1:0] taddr [NUM_CELLS+1];
	logic [CODE_W-1:0] tcode [NUM_CELLS+1];

	lzwc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign cap      = (cfg.cap_pow < DICT_POS) ? cfg.cap_pow : DICT_POS;
	assign room     = next_free_q < cap;
	assign in_sym   = symbol & cfg.sym_mask;
	assign miss_sym = (state_q == ST_IDLE) ? in_sym : sym_q;
	assign nf_m1    = next_free_q - 13'd1;

	assign item_stall    = (state_q != ST_IDLE);
	assign take_item     = item_valid && !item_stall;
	assign result_valid  = out_valid_q;
	assign code          = code_q;
	assign dict_position = dict_pos_q;

	// head of the chain
	assign tok[0].valid = scan_issue;
	assign tok[0].last  = (cnt_q == last_addr_q);
	assign tok[0].hit   = 1'b0;
	assign taddr[0]     = cnt_q;
	assign tcode[0]     = '0;

	genvar gi;
	generate
		for (gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
			assign cell_wr[gi] = do_miss && room &&
				(next_free_q[CELL_BITS-1:0] == CELL_BITS'(gi));

			lzwc_cell #(
				.ADDR_W   (ADDR_W),
				.CELL_IDX (gi)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.in_tok     (tok[gi]),
				.in_addr    (taddr[gi]),
				.in_code    (tcode[gi]),
				.key_prefix (prefix_code_q),
				.key_sym    (sym_q),
				.lo_code    (cfg.first),
				.hi_code    (next_free_q),
				.wr_en      (cell_wr[gi]),
				.wr_addr    (next_free_q[CODE_W-1:CELL_BITS]),
				.wr_prefix  (prefix_code_q),
				.wr_sym     (miss_sym),
				.out_tok    (tok[gi+1]),
				.out_addr   (taddr[gi+1]),
				.out_code   (tcode[gi+1])
			);
		end
	endgenerate

	assign final_code = tok[NUM_CELLS].hit ? tcode[NUM_CELLS] : hit_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		scan_issue = 1'b0;
		do_hit     = 1'b0;
		do_miss    = 1'b0;
		do_flush   = 1'b0;
		do_clear   = 1'b0;
		do_first   = 1'b0;
		start_scan = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (take_item) begin
					case (cmd_t'(command))
						CMD_CLEAR: do_clear = 1'b1;
						CMD_FLUSH: begin
							if (prefix_valid_q) begin
								do_flush = 1'b1;
								state_d  = ST_EMIT;
							end
						end
						CMD_SYMBOL: begin
							if (!prefix_valid_q) begin
								do_first = 1'b1;
							end else if (next_free_q <= cfg.first) begin
								// empty dictionary: nothing to search
								do_miss = 1'b1;
								state_d = ST_EMIT;
							end else begin
								start_scan = 1'b1;
								state_d    = ST_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				scan_issue = 1'b1;
				if (cnt_q == last_addr_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (tok[NUM_CELLS].valid && tok[NUM_CELLS].last) begin
					if (hit_q || tok[NUM_CELLS].hit) begin
						do_hit  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						do_miss = 1'b1;
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || !result_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_valid_q <= 1'b0;
			prefix_code_q  <= '0;
			next_free_q    <= RESET_FIRST;
			hit_q          <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (do_clear) begin
				prefix_valid_q <= 1'b0;
				prefix_code_q  <= '0;
				next_free_q    <= cfg.first;
			end
			if (do_first) begin
				prefix_valid_q <= 1'b1;
				prefix_code_q  <= CODE_W'(in_sym);
			end
			if (do_hit) begin
				prefix_code_q <= final_code;
			end
			if (do_miss) begin
				prefix_code_q <= CODE_W'(miss_sym);
				if (room) begin
					next_free_q <= next_free_q + 13'd1;
				end
			end
			// sticky hit over the tokens of one search
			if (start_scan) begin
				hit_q <= 1'b0;
			end else if (tok[NUM_CELLS].valid && tok[NUM_CELLS].hit) begin
				hit_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_scan) begin
			sym_q       <= in_sym;
			cnt_q       <= cfg.first[CODE_W-1:CELL_BITS];
			last_addr_q <= nf_m1[CODE_W-1:CELL_BITS];
		end else if (scan_issue) begin
			cnt_q <= cnt_q + ADDR_W'(1);
		end
		if (tok[NUM_CELLS].valid && tok[NUM_CELLS].hit && !tok[NUM_CELLS].last) begin
			hit_code_q <= tcode[NUM_CELLS];
		end
		if (do_flush) begin
			res_code_q <= CODE_OUT_W'(prefix_code_q);
			res_pos_q  <= next_free_q;
		end
		if (do_miss) begin
			res_code_q <= CODE_OUT_W'(prefix_code_q);
			res_pos_q  <= room ? next_free_q + 13'd1 : next_free_q;
		end
		if (load_out) begin
			code_q     <= res_code_q;
			dict_pos_q <= res_pos_q;
		end
	end

	// chain tokens only exist while a search is running
	a_tok_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		tok[NUM_CELLS].valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("search token outside of a search");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_wr))
		else $error("more than one cell written");

	a_write_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(|cell_wr) |=> (next_free_q == $past(next_free_q) + 13'd1))
		else $error("dictionary write without next_free advance");

	a_hit_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		do_hit |=> (state_q == ST_IDLE && !$rose(out_valid_q)))
		else $error("result emitted on a dictionary hit");

endmodule
